### hdl/lzw_pkg.sv
`timescale 1ns / 1ps
package lzw_pkg;
  localparam int DictEntries = 65536;
  localparam int CodeW = 16;
  localparam int SlotW = 17;
  localparam int HashSlots = 2 * DictEntries;
  localparam logic [8:0] FirstFree = 9'd257;
  localparam logic [4:0] MinBits = 5'd9;
  localparam logic [0:0] RegMaxBits = 1'b0;
  localparam logic [0:0] RegHeader = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic probe_next;
    logic insert;
    logic hit;
    logic miss;
    logic flush_code;
    logic push_hdr;
    logic [1:0] hdr_idx;
    logic push_acc;
    logic push_final;
    logic clear_step;
    logic finish;
  } lzw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic header_sent;
    logic prefix_valid;
    logic slot_empty;
    logic slot_match;
    logic acc_has_byte;
    logic clear_done;
    logic init_done;
  } lzw_stat_t;

  function automatic logic [4:0] eff_bits(input logic [4:0] m);
    if (m < MinBits) return MinBits;
    if (m > 5'd16) return 5'd16;
    return m;
  endfunction

  function automatic logic [SlotW-1:0] hash_slot(input logic [23:0] key);
    logic [31:0] p;
    p = 32'(key) * 32'd2654435761;
    return p[SlotW-1:0];
  endfunction
endpackage

### hdl/lzw_datapath.sv
`timescale 1ns / 1ps
module lzw_datapath import lzw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  lzw_cmd_t  cmd,
  input  in_item_t  in_item,
  input  logic [4:0] max_code_bits,
  input  logic      out_ready,
  output lzw_stat_t stat,
  output out_item_t out_item,
  output logic      out_valid
);
  logic [CodeW-1:0] prefix_code;
  logic prefix_valid;
  logic [16:0] next_free_code;
  logic [4:0] code_width;
  logic [23:0] acc;
  logic [4:0] bit_count;
  logic header_sent;
  logic [7:0] cur_byte;
  logic [SlotW-1:0] slot;
  logic clearing;
  logic init_busy;
  logic [SlotW-1:0] init_ptr;

  // slot memory: key+1 (25 bits) and code, valid via key nonzero
  logic [24:0] key_mem [HashSlots];
  logic [CodeW-1:0] code_mem [HashSlots];
  logic [SlotW-1:0] back_mem [DictEntries];
  logic [24:0] rd_key;
  logic [CodeW-1:0] rd_code;
  logic [SlotW-1:0] rd_back;

  logic [23:0] key;
  logic [24:0] key_p1;
  logic [16:0] limit;
  logic can_add;
  logic [15:0] emit_val;
  logic [4:0] emit_w;
  logic [SlotW-1:0] slot_probe;
  logic [SlotW-1:0] slot_rd;
  logic [15:0] clr_code;

  assign key = {prefix_code, cur_byte};
  assign key_p1 = {1'b0, key} + 25'd1;
  assign limit = 17'd1 << eff_bits(max_code_bits);
  assign can_add = next_free_code < limit;
  assign slot_probe = (slot == SlotW'(HashSlots - 1)) ? '0 : slot + 1'b1;
  assign slot_rd = cmd.start ? hash_slot({prefix_code, in_item.data_byte})
                             : slot_probe;
  assign clr_code = 16'(next_free_code - 17'd1);

  always_ff @(posedge clk) begin
    if (clearing) begin
      rd_back <= back_mem[clr_code];
    end
    if (init_busy) begin
      key_mem[init_ptr] <= '0;
    end else if (cmd.clear_step && clearing) begin
      key_mem[rd_back] <= '0;
    end else if (cmd.insert && can_add) begin
      key_mem[slot] <= key_p1;
      code_mem[slot] <= next_free_code[15:0];
      back_mem[next_free_code[15:0]] <= slot;
    end
    if (cmd.start || cmd.probe_next) begin
      rd_key <= key_mem[slot_rd];
      rd_code <= code_mem[slot_rd];
    end
  end

  assign stat.slot_empty = rd_key == '0;
  assign stat.slot_match = rd_key == key_p1;
  assign stat.header_sent = header_sent;
  assign stat.prefix_valid = prefix_valid;
  assign stat.acc_has_byte = bit_count >= 5'd8;
  assign stat.clear_done = !clearing;
  assign stat.init_done = !init_busy;

  always_comb begin
    emit_val = prefix_code;
    emit_w = code_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_code <= '0;
      prefix_valid <= 1'b0;
      next_free_code <= 17'(FirstFree);
      code_width <= MinBits;
      acc <= '0;
      bit_count <= '0;
      header_sent <= 1'b0;
      out_valid <= 1'b0;
      clearing <= 1'b0;
      slot <= '0;
      init_busy <= 1'b1;
      init_ptr <= '0;
    end else begin
      if (init_busy) begin
        init_ptr <= init_ptr + 1'b1;
        if (init_ptr == SlotW'(HashSlots - 1)) init_busy <= 1'b0;
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.start) begin
        cur_byte <= in_item.data_byte;
        slot <= slot_rd;
        header_sent <= 1'b1;
        if (!prefix_valid) begin
          prefix_code <= 16'(in_item.data_byte);
          prefix_valid <= 1'b1;
        end
      end
      if (cmd.probe_next) slot <= slot_probe;
      if (cmd.hit) prefix_code <= rd_code;
      if (cmd.miss) begin
        acc <= acc | (24'(emit_val) << bit_count);
        bit_count <= bit_count + emit_w;
        prefix_code <= 16'(cur_byte);
        if (can_add) begin
          next_free_code <= next_free_code + 17'd1;
          if (next_free_code >= (17'd1 << code_width)) code_width <= code_width + 5'd1;
        end
      end
      if (cmd.flush_code) begin
        acc <= acc | (24'(emit_val) << bit_count);
        bit_count <= bit_count + emit_w;
      end
      if (cmd.push_hdr) begin
        out_valid <= 1'b1;
        unique case (cmd.hdr_idx)
          2'd0: out_item <= '{8'h1f, 1'b0};
          2'd1: out_item <= '{8'h9d, 1'b0};
          default: out_item <= '{8'h80 | 8'(eff_bits(max_code_bits)), 1'b0};
        endcase
      end
      if (cmd.push_acc) begin
        out_valid <= 1'b1;
        out_item <= '{acc[7:0], 1'b0};
        acc <= acc >> 8;
        bit_count <= bit_count - 5'd8;
      end
      if (cmd.push_final) begin
        out_valid <= 1'b1;
        out_item <= '{acc[7:0], 1'b1};
        clearing <= next_free_code != 17'(FirstFree);
      end
      if (cmd.clear_step && clearing) begin
        if (next_free_code <= 17'(FirstFree) + 17'd1) begin
          clearing <= 1'b0;
          next_free_code <= 17'(FirstFree);
        end else begin
          next_free_code <= next_free_code - 17'd1;
        end
      end
      if (cmd.finish) begin
        prefix_code <= '0;
        prefix_valid <= 1'b0;
        next_free_code <= 17'(FirstFree);
        code_width <= MinBits;
        acc <= '0;
        bit_count <= '0;
        header_sent <= 1'b0;
      end
    end
  end
endmodule

### hdl/lzw_ctrl.sv
`timescale 1ns / 1ps
module lzw_ctrl import lzw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_last,
  input  logic      header_enable,
  input  lzw_stat_t stat,
  input  logic      out_valid,
  input  logic      out_ready,
  output logic      in_ready,
  output lzw_cmd_t  cmd
);
  localparam logic [3:0] S_IDLE = 4'd0, S_HDR = 4'd1, S_LOOK = 4'd2, S_CMP = 4'd3,
    S_DRAIN = 4'd4, S_FLUSH = 4'd5, S_FDRAIN = 4'd6, S_FINAL = 4'd7,
    S_CLR0 = 4'd8, S_CLR = 4'd9, S_WAIT = 4'd10;
  logic [3:0] state, state_next;
  logic [1:0] hdr, hdr_next;
  logic last, last_next, first, first_next;
  logic out_free;
  assign out_free = !out_valid || out_ready;

  always_comb begin
    state_next = state;
    hdr_next = hdr;
    last_next = last;
    first_next = first;
    cmd = '0;
    in_ready = state == S_IDLE && stat.init_done;
    unique case (state)
      S_IDLE: if (in_valid && stat.init_done) begin
        cmd.start = 1'b1;
        last_next = in_last;
        first_next = !stat.prefix_valid;
        hdr_next = 2'd0;
        state_next = (!stat.header_sent && header_enable) ? S_HDR : S_WAIT;
      end
      S_WAIT: state_next = first ? (last ? S_FLUSH : S_IDLE) : S_CMP;
      S_HDR: if (out_free) begin
        cmd.push_hdr = 1'b1;
        cmd.hdr_idx = hdr;
        hdr_next = hdr + 2'd1;
        if (hdr == 2'd2) state_next = S_WAIT;
      end
      S_LOOK: begin
        state_next = S_CMP;
      end
      S_CMP: begin
        if (stat.slot_match) begin
          cmd.hit = 1'b1;
          state_next = last ? S_FLUSH : S_IDLE;
        end else if (stat.slot_empty) begin
          cmd.insert = 1'b1;
          cmd.miss = 1'b1;
          state_next = S_DRAIN;
        end else begin
          cmd.probe_next = 1'b1;
          state_next = S_LOOK;
        end
      end
      S_DRAIN: if (stat.acc_has_byte) begin
        if (out_free) cmd.push_acc = 1'b1;
      end else state_next = last ? S_FLUSH : S_IDLE;
      S_FLUSH: begin
        cmd.flush_code = 1'b1;
        state_next = S_FDRAIN;
      end
      S_FDRAIN: if (stat.acc_has_byte) begin
        if (out_free) cmd.push_acc = 1'b1;
      end else state_next = S_FINAL;
      S_FINAL: if (out_free) begin
        cmd.push_final = 1'b1;
        state_next = S_CLR0;
      end
      S_CLR0: state_next = S_CLR;
      S_CLR: begin
        if (stat.clear_done) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end else begin
          cmd.clear_step = 1'b1;
          state_next = S_CLR0;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hdr <= '0;
      last <= 1'b0;
      first <= 1'b0;
    end else begin
      state <= state_next;
      hdr <= hdr_next;
      last <= last_next;
      first <= first_next;
    end
  end
endmodule

### hdl/lzw_compressor_variable_width_unit.sv
`timescale 1ns / 1ps
// lzw compressor, codes 9 to 16 bits, packed lsb first
// input channel: in_valid/in_ready with data_byte and last_byte
// output channel: out_valid/out_ready with out_byte and out_last
// config: cfg_we, cfg_index, cfg_data; index 0 max_code_bits, 1 header_enable
// one input byte per transaction; the controller takes one byte at a time
// a byte that extends the prefix is accepted, waited on and then compared;
// a missing string inserts the entry and then drains its output bytes;
// each collision probe adds a look and a compare; the three header bytes
// are sent one at a time before the first code when header_enable is set
// on last_byte the prefix code is flushed, then a zero-padded final byte
// with out_last; afterwards the inserted entries are erased one at a time
// before the next byte is taken
// after reset every hash slot is cleared while in_ready is held low
// an output stall holds the controller until the output register frees
module lzw_compressor_variable_width_unit import lzw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data,
  input  logic      cfg_we,
  input  logic      cfg_index,
  input  logic [4:0] cfg_data
);
  logic [4:0] max_code_bits;
  logic header_enable;
  lzw_cmd_t cmd;
  lzw_stat_t stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_code_bits <= 5'd16;
      header_enable <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegMaxBits: max_code_bits <= cfg_data;
        RegHeader: header_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  lzw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_last(in_data.last_byte),
    .header_enable(header_enable), .stat(stat), .out_valid(out_valid),
    .out_ready(out_ready), .in_ready(in_ready), .cmd(cmd)
  );

  lzw_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_item(in_data),
    .max_code_bits(max_code_bits), .out_ready(out_ready), .stat(stat),
    .out_item(out_data), .out_valid(out_valid)
  );
endmodule
